[rtl/nearest_neighbor_by_class_unit_assert.svh]
// Assertion macros shared by the nearest-neighbor checker.
`ifndef NEAREST_NEIGHBOR_BY_CLASS_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_BY_CLASS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NNBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NNBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nnbc_pkg.sv]
// Package with the payload types, constants and controller states of the unit.
package nnbc_pkg;

  // Field widths of the transfers.
  localparam int POS_W      = 12;
  localparam int IDX_OUT_W  = 6;
  localparam int DIST_OUT_W = 25;
  localparam int CNT_OUT_W  = 6;
  localparam int THR_W      = 25;

  // Defaults for the top-level parameters.
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 12;

  // Density threshold after reset.
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(200);

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             is_zombie;
    logic             last_point;
  } nnbc_in_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  point_index;
    logic                  zombie_found;
    logic [IDX_OUT_W-1:0]  zombie_index;
    logic [DIST_OUT_W-1:0] zombie_dist_sq;
    logic                  human_found;
    logic [IDX_OUT_W-1:0]  human_index;
    logic [DIST_OUT_W-1:0] human_dist_sq;
    logic [CNT_OUT_W-1:0]  close_humans;
    logic [IDX_OUT_W-1:0]  densest_index;
    logic [CNT_OUT_W-1:0]  densest_count;
    logic                  last_result;
  } nnbc_out_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FEED,
    ST_DRAIN
  } nnbc_state_e;

endpackage

[rtl/nearest_neighbor_by_class_unit.sv]
// Top level of the nearest-neighbor-by-class unit: load control, query feed, cell chain.
//
// Usage. Points are loaded one per transfer on item_i, taken at a clock edge
// where start is high and busy is low. The point with last_point set ends the
// load (points beyond MAX_POINTS are dropped, but a dropped last point still
// ends it). The unit then raises busy and emits one result per stored point,
// in index order, on result_o, each marked by result_valid_o for one cycle.
// Results cannot be held off, so there is no stall on the output side.
// Each stored point is fed as a query into a chain of MAX_POINTS cells, two
// register stages per cell; after the last point's transfer the results
// follow one per cycle, and busy stays high until the query of the last
// stored point reaches the end of the chain. While busy is low, points can be
// loaded one per cycle. The density threshold is written through cfg_we_i/cfg_wdata_i
// while idle; the user is bound to this, the block itself does not enforce it.
// Reset clears the load count, the controller and the running densest point,
// and sets the threshold to 200.
module nearest_neighbor_by_class_unit import nnbc_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  nnbc_in_t         item_i,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  output logic             result_valid_o,
  output nnbc_out_t        result_o
);

  localparam int CW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
  localparam int DW    = 2 * CW + 1;
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PW    = 2 * CW + 1;

  // Threshold register.
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Controller.
  nnbc_state_e      state_q, state_d;
  logic             in_xfer, store_en, feed_en, feed_last, chain_last;
  logic [CNT_W-1:0] count_q;
  logic [IW-1:0]    feed_idx_q;

  assign in_xfer   = start && !busy;
  assign store_en  = in_xfer && (count_q < CNT_W'(MAX_POINTS));
  assign feed_last = CNT_W'(feed_idx_q) == (count_q - CNT_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_xfer && item_i.last_point) state_d = ST_FEED;
      ST_FEED:  if (feed_last) state_d = ST_DRAIN;
      ST_DRAIN: if (chain_last) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    feed_en = 1'b0;
    unique case (state_q)
      ST_LOAD:  busy = 1'b0;
      ST_FEED:  feed_en = 1'b1;
      ST_DRAIN: busy = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      feed_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_DRAIN) && chain_last) begin
        count_q <= '0;
      end else if (store_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (feed_en) begin
        feed_idx_q <= feed_last ? '0 : feed_idx_q + IW'(1);
      end
    end
  end

  // Coordinate memory for the query feed; the class flag lives in the cells.
  logic [2*CW-1:0] point_mem [MAX_POINTS];
  logic [PW-1:0]   wr_word;
  logic [2*CW-1:0] mem_rd_q;
  logic            issue_v_q;
  logic [IW-1:0]   issue_idx_q;

  assign wr_word = {item_i.is_zombie, item_i.pos_y[CW-1:0], item_i.pos_x[CW-1:0]};

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      point_mem[count_q[IW-1:0]] <= wr_word[2*CW-1:0];
    end
    mem_rd_q    <= point_mem[feed_idx_q];
    issue_idx_q <= feed_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_v_q <= 1'b0;
    end else begin
      issue_v_q <= feed_en;
    end
  end

  // Cell chain; position 0 is the feed, position MAX_POINTS the chain end.
  logic          ch_v     [MAX_POINTS+1];
  logic [IW-1:0] ch_idx   [MAX_POINTS+1];
  logic [CW-1:0] ch_qx    [MAX_POINTS+1];
  logic [CW-1:0] ch_qy    [MAX_POINTS+1];
  logic          ch_zf    [MAX_POINTS+1];
  logic [IW-1:0] ch_zi    [MAX_POINTS+1];
  logic [DW-1:0] ch_zd    [MAX_POINTS+1];
  logic          ch_hf    [MAX_POINTS+1];
  logic [IW-1:0] ch_hi    [MAX_POINTS+1];
  logic [DW-1:0] ch_hd    [MAX_POINTS+1];
  logic [IW-1:0] ch_close [MAX_POINTS+1];

  assign ch_v[0]     = issue_v_q;
  assign ch_idx[0]   = issue_idx_q;
  assign ch_qx[0]    = mem_rd_q[CW-1:0];
  assign ch_qy[0]    = mem_rd_q[2*CW-1:CW];
  assign ch_zf[0]    = 1'b0;
  assign ch_zi[0]    = '0;
  assign ch_zd[0]    = '0;
  assign ch_hf[0]    = 1'b0;
  assign ch_hi[0]    = '0;
  assign ch_hd[0]    = '0;
  assign ch_close[0] = '0;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    nnbc_cell #(
      .CW       (CW),
      .IW       (IW),
      .CNT_W    (CNT_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_en_i (store_en && (count_q == CNT_W'(k))),
      .wr_x_i  (wr_word[CW-1:0]),
      .wr_y_i  (wr_word[2*CW-1:CW]),
      .wr_z_i  (wr_word[2*CW]),
      .count_i (count_q),
      .thr_i   (thr_q),
      .v_i     (ch_v[k]),
      .idx_i   (ch_idx[k]),
      .qx_i    (ch_qx[k]),
      .qy_i    (ch_qy[k]),
      .zf_i    (ch_zf[k]),
      .zi_i    (ch_zi[k]),
      .zd_i    (ch_zd[k]),
      .hf_i    (ch_hf[k]),
      .hi_i    (ch_hi[k]),
      .hd_i    (ch_hd[k]),
      .close_i (ch_close[k]),
      .v_o     (ch_v[k+1]),
      .idx_o   (ch_idx[k+1]),
      .qx_o    (ch_qx[k+1]),
      .qy_o    (ch_qy[k+1]),
      .zf_o    (ch_zf[k+1]),
      .zi_o    (ch_zi[k+1]),
      .zd_o    (ch_zd[k+1]),
      .hf_o    (ch_hf[k+1]),
      .hi_o    (ch_hi[k+1]),
      .hd_o    (ch_hd[k+1]),
      .close_o (ch_close[k+1])
    );
  end

  // The query coordinates are only needed inside the chain.
  logic [CW-1:0] end_qx_unused, end_qy_unused;
  assign end_qx_unused = ch_qx[MAX_POINTS];
  assign end_qy_unused = ch_qy[MAX_POINTS];

  assign chain_last = ch_v[MAX_POINTS] &&
                      (CNT_W'(ch_idx[MAX_POINTS]) == (count_q - CNT_W'(1)));

  // Distance fields clipped to the output width, or zero-extended when they fit.
  logic [DIST_OUT_W-1:0] zd_out, hd_out;

  if (DW > DIST_OUT_W) begin : g_sat
    assign zd_out = (ch_zd[MAX_POINTS] > DW'({DIST_OUT_W{1'b1}})) ?
                    {DIST_OUT_W{1'b1}} : ch_zd[MAX_POINTS][DIST_OUT_W-1:0];
    assign hd_out = (ch_hd[MAX_POINTS] > DW'({DIST_OUT_W{1'b1}})) ?
                    {DIST_OUT_W{1'b1}} : ch_hd[MAX_POINTS][DIST_OUT_W-1:0];
  end else begin : g_ext
    assign zd_out = DIST_OUT_W'(ch_zd[MAX_POINTS]);
    assign hd_out = DIST_OUT_W'(ch_hd[MAX_POINTS]);
  end

  // Running densest point, restarted by point 0.
  logic [IW-1:0] best_cnt_q, best_cnt_d, best_idx_q, best_idx_d;
  logic          best_upd;

  always_comb begin
    best_upd   = (ch_idx[MAX_POINTS] == '0) || (ch_close[MAX_POINTS] > best_cnt_q);
    best_cnt_d = best_upd ? ch_close[MAX_POINTS] : best_cnt_q;
    best_idx_d = best_upd ? ch_idx[MAX_POINTS] : best_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_cnt_q     <= '0;
      best_idx_q     <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= ch_v[MAX_POINTS];
      if (ch_v[MAX_POINTS]) begin
        best_cnt_q <= best_cnt_d;
        best_idx_q <= best_idx_d;
      end
    end
  end

  // Result register.
  nnbc_out_t res_d;

  always_comb begin
    res_d.point_index    = IDX_OUT_W'(ch_idx[MAX_POINTS]);
    res_d.zombie_found   = ch_zf[MAX_POINTS];
    res_d.zombie_index   = IDX_OUT_W'(ch_zi[MAX_POINTS]);
    res_d.zombie_dist_sq = zd_out;
    res_d.human_found    = ch_hf[MAX_POINTS];
    res_d.human_index    = IDX_OUT_W'(ch_hi[MAX_POINTS]);
    res_d.human_dist_sq  = hd_out;
    res_d.close_humans   = CNT_OUT_W'(ch_close[MAX_POINTS]);
    res_d.densest_index  = IDX_OUT_W'(best_idx_d);
    res_d.densest_count  = CNT_OUT_W'(best_cnt_d);
    res_d.last_result    = chain_last;
  end

  always_ff @(posedge clk_i) begin
    if (ch_v[MAX_POINTS]) begin
      result_o <= res_d;
    end
  end

endmodule

[rtl/nnbc_cell.sv]
// One cell of the scan chain: holds a stored point and updates a passing query.
module nnbc_cell import nnbc_pkg::*; #(
  parameter int CW       = 12,
  parameter int IW       = 6,
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Point load.
  input  logic             wr_en_i,
  input  logic [CW-1:0]    wr_x_i,
  input  logic [CW-1:0]    wr_y_i,
  input  logic             wr_z_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [THR_W-1:0] thr_i,
  // Query and accumulator from the previous cell.
  input  logic             v_i,
  input  logic [IW-1:0]    idx_i,
  input  logic [CW-1:0]    qx_i,
  input  logic [CW-1:0]    qy_i,
  input  logic             zf_i,
  input  logic [IW-1:0]    zi_i,
  input  logic [2*CW:0]    zd_i,
  input  logic             hf_i,
  input  logic [IW-1:0]    hi_i,
  input  logic [2*CW:0]    hd_i,
  input  logic [IW-1:0]    close_i,
  // Query and accumulator to the next cell.
  output logic             v_o,
  output logic [IW-1:0]    idx_o,
  output logic [CW-1:0]    qx_o,
  output logic [CW-1:0]    qy_o,
  output logic             zf_o,
  output logic [IW-1:0]    zi_o,
  output logic [2*CW:0]    zd_o,
  output logic             hf_o,
  output logic [IW-1:0]    hi_o,
  output logic [2*CW:0]    hd_o,
  output logic [IW-1:0]    close_o
);

  localparam int DW = 2 * CW + 1;
  localparam int TW = (DW > THR_W) ? DW : THR_W;

  // Stored point of this cell.
  logic [CW-1:0] p_x_q, p_y_q;
  logic          p_z_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      p_x_q <= wr_x_i;
      p_y_q <= wr_y_i;
      p_z_q <= wr_z_i;
    end
  end

  // First stage: absolute differences, squared.
  logic [CW-1:0]   dx, dy;
  logic            a_v_q;
  logic [IW-1:0]   a_idx_q, a_zi_q, a_hi_q, a_close_q;
  logic [CW-1:0]   a_qx_q, a_qy_q;
  logic            a_zf_q, a_hf_q;
  logic [DW-1:0]   a_zd_q, a_hd_q;
  logic [2*CW-1:0] a_dx2_q, a_dy2_q;

  assign dx = (qx_i > p_x_q) ? (qx_i - p_x_q) : (p_x_q - qx_i);
  assign dy = (qy_i > p_y_q) ? (qy_i - p_y_q) : (p_y_q - qy_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_idx_q   <= idx_i;
    a_qx_q    <= qx_i;
    a_qy_q    <= qy_i;
    a_zf_q    <= zf_i;
    a_zi_q    <= zi_i;
    a_zd_q    <= zd_i;
    a_hf_q    <= hf_i;
    a_hi_q    <= hi_i;
    a_hd_q    <= hd_i;
    a_close_q <= close_i;
    a_dx2_q   <= dx * dx;
    a_dy2_q   <= dy * dy;
  end

  // Second stage: distance, compare against the running bests.
  // Cells are visited in ascending index order, so on a tie a candidate
  // below the query index wins over an earlier lower one, while above the
  // query index the earlier candidate keeps its place.
  logic [DW-1:0] dist_sq;
  logic          cand, lower, z_upd, h_upd, is_close;

  always_comb begin
    dist_sq  = {1'b0, a_dx2_q} + {1'b0, a_dy2_q};
    cand     = a_v_q && (CNT_W'(CELL_IDX) < count_i) && (IW'(CELL_IDX) != a_idx_q);
    lower    = IW'(CELL_IDX) < a_idx_q;
    z_upd    = cand && p_z_q &&
               (!a_zf_q || (dist_sq < a_zd_q) || ((dist_sq == a_zd_q) && lower));
    h_upd    = cand && !p_z_q &&
               (!a_hf_q || (dist_sq < a_hd_q) || ((dist_sq == a_hd_q) && lower));
    is_close = cand && !p_z_q && (TW'(dist_sq) < TW'(thr_i));
  end

  logic          b_v_q;
  logic [IW-1:0] b_idx_q, b_zi_q, b_hi_q, b_close_q;
  logic [CW-1:0] b_qx_q, b_qy_q;
  logic          b_zf_q, b_hf_q;
  logic [DW-1:0] b_zd_q, b_hd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_idx_q   <= a_idx_q;
    b_qx_q    <= a_qx_q;
    b_qy_q    <= a_qy_q;
    b_zf_q    <= a_zf_q | z_upd;
    b_zi_q    <= z_upd ? IW'(CELL_IDX) : a_zi_q;
    b_zd_q    <= z_upd ? dist_sq : a_zd_q;
    b_hf_q    <= a_hf_q | h_upd;
    b_hi_q    <= h_upd ? IW'(CELL_IDX) : a_hi_q;
    b_hd_q    <= h_upd ? dist_sq : a_hd_q;
    b_close_q <= a_close_q + IW'(is_close);
  end

  assign v_o     = b_v_q;
  assign idx_o   = b_idx_q;
  assign qx_o    = b_qx_q;
  assign qy_o    = b_qy_q;
  assign zf_o    = b_zf_q;
  assign zi_o    = b_zi_q;
  assign zd_o    = b_zd_q;
  assign hf_o    = b_hf_q;
  assign hi_o    = b_hi_q;
  assign hd_o    = b_hd_q;
  assign close_o = b_close_q;

endmodule

[rtl/nnbc_checker.sv]
// Port-level checker for the nearest-neighbor-by-class unit, bound to the top level.
`include "nearest_neighbor_by_class_unit_assert.svh"

module nnbc_checker import nnbc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input nnbc_in_t         item_i,
  input logic             result_valid_o,
  input nnbc_out_t        result_o
);

  // The transfer that ends a load starts the computation.
  `NNBC_ASSERT_NEXT(a_last_sets_busy, clk_i, rst_ni, start && !busy && item_i.last_point, busy, "last point did not raise busy")

  // Only the final result may be shown once the unit is idle again.
  `NNBC_ASSERT_NOW(a_result_while_busy, clk_i, rst_ni, result_valid_o && !result_o.last_result, busy, "non-final result while idle")

  // Results of one load come back to back in index order.
  `NNBC_ASSERT_NEXT(a_results_in_order, clk_i, rst_ni, result_valid_o && !result_o.last_result, result_valid_o && (result_o.point_index == IDX_OUT_W'($past(result_o.point_index) + 1'b1)), "results not consecutive")

  // The running densest point starts at point 0.
  `NNBC_ASSERT_NOW(a_densest_start, clk_i, rst_ni, result_valid_o && (result_o.point_index == '0), result_o.densest_index == '0, "densest index not restarted at point 0")

endmodule

bind nearest_neighbor_by_class_unit nnbc_checker u_nnbc_checker (.*);
